/* src/scc_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the sensor calibration compensation core
package scc_pkg;

  localparam int NUM_W     = 64;
  localparam int DEN_W     = 31;
  localparam int DIV_STEPS = NUM_W;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_TEMP      = 3'd0,
    REG_PRESS_LO  = 3'd1,
    REG_PRESS_HI  = 3'd2,
    REG_PRESS_HUM = 3'd3,
    REG_HUM       = 3'd4
  } reg_idx_t;

  // compensation constants
  localparam logic signed [32:0] T_PRESS_OFFSET = 33'sd128000;
  localparam logic [20:0]        P_BASE         = 21'd1048576;
  localparam logic [63:0]        P_SCALE        = 64'd3125;
  localparam logic [63:0]        P_DIV_BIAS     = 64'h0000_8000_0000_0000;
  localparam logic signed [31:0] T_ROUND        = 32'sd128;
  localparam logic signed [31:0] H_OFFSET       = 32'sd76800;
  localparam logic signed [31:0] H_X_ROUND      = 32'sd16384;
  localparam logic signed [31:0] H_Y_BIAS       = 32'sd32768;
  localparam logic signed [31:0] H_Y_OFFSET     = 32'sd2097152;
  localparam logic signed [31:0] H_Y_ROUND      = 32'sd8192;
  localparam logic signed [31:0] H_MAX          = 32'sd419430400;

  // unpacked calibration coefficients
  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic [7:0]         h1;
    logic signed [15:0] h2;
    logic [7:0]         h3;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
  } coeff_t;

  // results that ride along the divider
  typedef struct packed {
    logic [16:0] hum;
    logic [23:0] temp;
  } side_t;

endpackage

/* src/scc_temp.sv */
`timescale 1ns / 1ps
// three-stage fine temperature pipeline
module scc_temp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ce,
  input  logic                 in_vld,
  input  logic [19:0]          raw_temperature,
  input  logic [19:0]          raw_pressure,
  input  logic [15:0]          raw_humidity,
  input  scc_pkg::coeff_t      coeff,
  output logic                 out_vld,
  output logic signed [31:0]   tf,
  output logic [19:0]          adc_p,
  output logic [15:0]          adc_h
);

  logic signed [17:0] tx;
  logic signed [33:0] tp;
  logic signed [16:0] d;
  logic signed [33:0] dd;
  logic signed [31:0] v1;
  logic signed [31:0] ddsh;
  logic signed [31:0] v2p;

  logic               s1_vld, s2_vld;
  logic [31:0]        s1_v1p, s1_dd;
  logic [19:0]        s1_adc_p, s2_adc_p;
  logic [15:0]        s1_adc_h, s2_adc_h;
  logic signed [31:0] s2_v1, s2_v2p;

  always_comb begin
    tx   = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, coeff.t1, 1'b0});
    tp   = tx * coeff.t2;
    d    = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, coeff.t1});
    dd   = d * d;
    v1   = $signed(s1_v1p) >>> 11;
    ddsh = $signed(s1_dd) >>> 12;
    v2p  = ddsh * coeff.t3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      s2_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else if (ce) begin
      s1_vld  <= in_vld;
      s2_vld  <= s1_vld;
      out_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_v1p   <= tp[31:0];
      s1_dd    <= dd[31:0];
      s1_adc_p <= raw_pressure;
      s1_adc_h <= raw_humidity;
      s2_v1    <= v1;
      s2_v2p   <= v2p;
      s2_adc_p <= s1_adc_p;
      s2_adc_h <= s1_adc_h;
      tf       <= s2_v1 + (s2_v2p >>> 14);
      adc_p    <= s2_adc_p;
      adc_h    <= s2_adc_h;
    end
  end

endmodule

/* src/scc_ppre.sv */
`timescale 1ns / 1ps
// six-stage pressure pipeline up to the divider operands, plus output temperature
module scc_ppre (
  input  logic               clk,
  input  logic               rst,
  input  logic               ce,
  input  logic               in_vld,
  input  logic signed [31:0] tf,
  input  logic [19:0]        adc_p,
  input  scc_pkg::coeff_t    coeff,
  output logic               out_vld,
  output logic [63:0]        num_mag,
  output logic [30:0]        den_mag,
  output logic               q_neg,
  output logic               den_zero,
  output logic [23:0]        temp
);

  // stage 1 comb
  logic signed [32:0] a;
  logic signed [65:0] aa_full;
  logic signed [48:0] ap5_c, ap2_c;
  logic signed [31:0] t5;
  logic signed [31:0] t8;
  // stage 2 comb
  logic [31:0]        p6x, p3x;
  logic signed [48:0] m6l_c, m3l_c;
  logic [31:0]        m6h_c, m3h_c;
  // stage 3 comb
  logic [63:0]        m3_c;
  // stage 4 comb
  logic [63:0]        c_c;
  logic [47:0]        cl_c;
  logic [31:0]        ch_c;
  // stage 5 comb
  logic [63:0]        prod_c;

  logic [5:0]         vld;
  logic [23:0]        tmp1, tmp2, tmp3, tmp4, tmp5;
  logic [63:0]        s1_aa;
  logic signed [48:0] s1_ap5, s1_ap2, s2_ap5, s2_ap2;
  logic [20:0]        s1_pr, s2_pr, s3_pr;
  logic signed [48:0] s2_m6l, s2_m3l;
  logic [31:0]        s2_m6h, s2_m3h;
  logic [63:0]        s3_b, s3_a2;
  logic [47:0]        s4_cl;
  logic [31:0]        s4_ch;
  logic [63:0]        s4_n0;
  logic [30:0]        s5_a3;
  logic [63:0]        s5_n;

  always_comb begin
    a       = $signed({tf[31], tf}) - scc_pkg::T_PRESS_OFFSET;
    aa_full = a * a;
    ap5_c   = a * coeff.p5;
    ap2_c   = a * coeff.p2;
    t5      = (tf <<< 2) + tf + scc_pkg::T_ROUND;
    t8      = t5 >>> 8;

    p6x     = {{16{coeff.p6[15]}}, coeff.p6};
    p3x     = {{16{coeff.p3[15]}}, coeff.p3};
    m6l_c   = $signed({1'b0, s1_aa[31:0]}) * coeff.p6;
    m3l_c   = $signed({1'b0, s1_aa[31:0]}) * coeff.p3;
    m6h_c   = s1_aa[63:32] * p6x;
    m3h_c   = s1_aa[63:32] * p3x;

    m3_c    = {{15{s2_m3l[48]}}, s2_m3l} + {s2_m3h, 32'b0};

    c_c     = s3_a2 + scc_pkg::P_DIV_BIAS;
    cl_c    = c_c[31:0] * coeff.p1;
    ch_c    = c_c[63:32] * {16'b0, coeff.p1};

    prod_c  = {16'b0, s4_cl} + {s4_ch, 32'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[4:0], in_vld};
    end
  end

  assign out_vld = vld[5];

  always_ff @(posedge clk) begin
    if (ce) begin
      // stage 1: offset fine temperature and its square
      s1_aa  <= aa_full[63:0];
      s1_ap5 <= ap5_c;
      s1_ap2 <= ap2_c;
      s1_pr  <= scc_pkg::P_BASE - {1'b0, adc_p};
      tmp1   <= t8[23:0];
      // stage 2: square times p6 and p3, split in halves
      s2_m6l <= m6l_c;
      s2_m6h <= m6h_c;
      s2_m3l <= m3l_c;
      s2_m3h <= m3h_c;
      s2_ap5 <= s1_ap5;
      s2_ap2 <= s1_ap2;
      s2_pr  <= s1_pr;
      tmp2   <= tmp1;
      // stage 3: numerator offset and divisor terms
      s3_b   <= {{15{s2_m6l[48]}}, s2_m6l} + {s2_m6h, 32'b0}
                + {s2_ap5[46:0], 17'b0} + {{13{coeff.p4[15]}}, coeff.p4, 35'b0};
      s3_a2  <= 64'($signed(m3_c) >>> 8) + {{3{s2_ap2[48]}}, s2_ap2, 12'b0};
      s3_pr  <= s2_pr;
      tmp3   <= tmp2;
      // stage 4: scale divisor by p1
      s4_cl  <= cl_c;
      s4_ch  <= ch_c;
      s4_n0  <= {12'b0, s3_pr, 31'b0} - s3_b;
      tmp4   <= tmp3;
      // stage 5: divisor and scaled numerator
      s5_a3  <= prod_c[63:33];
      s5_n   <= s4_n0 * scc_pkg::P_SCALE;
      tmp5   <= tmp4;
      // stage 6: magnitudes and quotient sign
      num_mag  <= s5_n[63] ? (64'd0 - s5_n) : s5_n;
      den_mag  <= s5_a3[30] ? (31'd0 - s5_a3) : s5_a3;
      q_neg    <= s5_n[63] ^ s5_a3[30];
      den_zero <= (s5_a3 == 31'd0);
      temp     <= tmp5;
    end
  end

endmodule

/* src/scc_hum.sv */
`timescale 1ns / 1ps
// six-stage humidity pipeline
module scc_hum (
  input  logic               clk,
  input  logic               ce,
  input  logic signed [31:0] tf,
  input  logic [15:0]        adc_h,
  input  scc_pkg::coeff_t    coeff,
  output logic [16:0]        hum
);

  logic signed [31:0] v;
  logic signed [31:0] m5_c, m6_c, m3_c, u_c;
  logic signed [31:0] x_c, yp_c, y_c, yh_c, vv_c;
  logic signed [16:0] s17;
  logic signed [33:0] ss_full;
  logic signed [31:0] sh_c, w_c;
  logic [31:0]        clamp_c;

  logic signed [31:0] s1_u, s1_m5, s1_m6, s1_m3;
  logic signed [31:0] s2_x, s2_yp, s3_x, s3_yh, s4_vv, s5_vv, s5_ss;

  always_comb begin
    v    = tf - scc_pkg::H_OFFSET;
    m5_c = v * coeff.h5;
    m6_c = v * coeff.h6;
    m3_c = v * $signed({1'b0, coeff.h3});
    u_c  = $signed({2'b0, adc_h, 14'b0}) - $signed({coeff.h4, 20'b0}) + scc_pkg::H_X_ROUND;

    x_c  = (s1_u - s1_m5) >>> 15;
    yp_c = (s1_m6 >>> 10) * ((s1_m3 >>> 11) + scc_pkg::H_Y_BIAS);

    y_c  = (s2_yp >>> 10) + scc_pkg::H_Y_OFFSET;
    yh_c = y_c * coeff.h2 + scc_pkg::H_Y_ROUND;

    vv_c = s3_x * (s3_yh >>> 14);

    s17     = 17'(s4_vv >>> 15);
    ss_full = s17 * s17;

    sh_c = (s5_ss >>> 7) * $signed({1'b0, coeff.h1});
    w_c  = s5_vv - (sh_c >>> 4);
    if (w_c[31]) begin
      clamp_c = 32'd0;
    end else if (w_c > scc_pkg::H_MAX) begin
      clamp_c = 32'(scc_pkg::H_MAX);
    end else begin
      clamp_c = w_c;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_u  <= u_c;
      s1_m5 <= m5_c;
      s1_m6 <= m6_c;
      s1_m3 <= m3_c;
      s2_x  <= x_c;
      s2_yp <= yp_c;
      s3_x  <= s2_x;
      s3_yh <= yh_c;
      s4_vv <= vv_c;
      s5_vv <= s4_vv;
      s5_ss <= ss_full[31:0];
      hum   <= clamp_c[28:12];
    end
  end

endmodule

/* src/scc_div.sv */
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage
module scc_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              ce,
  input  logic                              in_vld,
  input  logic [scc_pkg::NUM_W-1:0]         num_mag,
  input  logic [scc_pkg::DEN_W-1:0]         den_mag,
  input  logic                              q_neg,
  input  logic                              den_zero,
  input  scc_pkg::side_t                    side,
  output logic                              out_vld,
  output logic [scc_pkg::NUM_W-1:0]         quot,
  output logic                              out_neg,
  output logic                              out_zero,
  output scc_pkg::side_t                    out_side
);

  localparam int N = scc_pkg::DIV_STEPS;
  localparam int R = scc_pkg::DEN_W;

  logic                         vld  [N];
  logic [R-1:0]                 rem  [N];
  logic [scc_pkg::NUM_W-1:0]    nq   [N];
  logic [R-1:0]                 den  [N];
  logic                         neg  [N];
  logic                         zero [N];
  scc_pkg::side_t               sd   [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic                       vld_i;
    logic [R-1:0]               rem_i;
    logic [scc_pkg::NUM_W-1:0]  nq_i;
    logic [R-1:0]               den_i;
    logic                       neg_i;
    logic                       zero_i;
    scc_pkg::side_t             sd_i;
    logic [R:0]                 trial;
    logic [R:0]                 diff;
    logic                       ge;

    if (k == 0) begin : g_head
      assign vld_i  = in_vld;
      assign rem_i  = '0;
      assign nq_i   = num_mag;
      assign den_i  = den_mag;
      assign neg_i  = q_neg;
      assign zero_i = den_zero;
      assign sd_i   = side;
    end else begin : g_body
      assign vld_i  = vld[k-1];
      assign rem_i  = rem[k-1];
      assign nq_i   = nq[k-1];
      assign den_i  = den[k-1];
      assign neg_i  = neg[k-1];
      assign zero_i = zero[k-1];
      assign sd_i   = sd[k-1];
    end

    assign trial = {rem_i, nq_i[scc_pkg::NUM_W-1]};
    assign ge    = (trial >= {1'b0, den_i});
    assign diff  = trial - {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (ce) begin
        vld[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem[k]  <= ge ? diff[R-1:0] : trial[R-1:0];
        nq[k]   <= {nq_i[scc_pkg::NUM_W-2:0], ge};
        den[k]  <= den_i;
        neg[k]  <= neg_i;
        zero[k] <= zero_i;
        sd[k]   <= sd_i;
      end
    end
  end

  assign out_vld  = vld[N-1];
  assign quot     = nq[N-1];
  assign out_neg  = neg[N-1];
  assign out_zero = zero[N-1];
  assign out_side = sd[N-1];

endmodule

/* src/scc_ppost.sv */
`timescale 1ns / 1ps
// five-stage pressure correction after the divider
module scc_ppost (
  input  logic               clk,
  input  logic               rst,
  input  logic               ce,
  input  logic               in_vld,
  input  logic [63:0]        quot,
  input  logic               q_neg,
  input  logic               den_zero,
  input  scc_pkg::side_t     side,
  input  scc_pkg::coeff_t    coeff,
  output logic               out_vld,
  output logic [23:0]        temperature_centi,
  output logic [31:0]        pressure_q24_8,
  output logic [16:0]        humidity_q22_10
);

  logic signed [63:0] sp;
  logic [25:0]        sl;
  logic signed [24:0] sh;
  logic [51:0]        ll_c;
  logic signed [51:0] hl_c;
  logic [23:0]        hh_c;
  logic [31:0]        p8x, p9x;
  logic signed [48:0] fl_c, el_c;
  logic [31:0]        fh_c, eh_c;
  logic [63:0]        ff_c;
  logic [63:0]        ee_c;
  logic [63:0]        e_c;
  logic [63:0]        x_c;
  logic [31:0]        res_c;

  logic [4:0]         vld;
  logic               z1, z2, z3, z4;
  scc_pkg::side_t     d1, d2, d3, d4;
  logic [63:0]        p1, p2, p3, p4;
  logic [51:0]        s2_ll;
  logic signed [51:0] s2_hl;
  logic [11:0]        s2_hh;
  logic signed [48:0] s2_fl;
  logic [31:0]        s2_fh;
  logic [63:0]        s3_ss, s3_f, s4_f;
  logic signed [48:0] s4_el;
  logic [31:0]        s4_eh;

  always_comb begin
    sp   = $signed(p1) >>> 13;
    sl   = sp[25:0];
    sh   = sp[50:26];
    ll_c = sl * sl;
    hl_c = sh * $signed({1'b0, sl});
    hh_c = sh[11:0] * sh[11:0];
    p8x  = {{16{coeff.p8[15]}}, coeff.p8};
    p9x  = {{16{coeff.p9[15]}}, coeff.p9};
    fl_c = $signed({1'b0, p1[31:0]}) * coeff.p8;
    fh_c = p1[63:32] * p8x;

    ff_c = {{15{s2_fl[48]}}, s2_fl} + {s2_fh, 32'b0};

    el_c = $signed({1'b0, s3_ss[31:0]}) * coeff.p9;
    eh_c = s3_ss[63:32] * p9x;

    ee_c  = {{15{s4_el[48]}}, s4_el} + {s4_eh, 32'b0};
    e_c   = 64'($signed(ee_c) >>> 25);
    x_c   = p4 + e_c + s4_f;
    res_c = x_c[39:8] + {{12{coeff.p7[15]}}, coeff.p7, 4'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[3:0], in_vld};
    end
  end

  assign out_vld = vld[4];

  always_ff @(posedge clk) begin
    if (ce) begin
      // stage 1: signed quotient
      p1    <= q_neg ? (64'd0 - quot) : quot;
      z1    <= den_zero;
      d1    <= side;
      // stage 2: partial products of the square and of p8 times p
      s2_ll <= ll_c;
      s2_hl <= hl_c;
      s2_hh <= hh_c[11:0];
      s2_fl <= fl_c;
      s2_fh <= fh_c;
      p2    <= p1;
      z2    <= z1;
      d2    <= d1;
      // stage 3: square of p over 2^13 and the p8 term
      s3_ss <= {12'b0, s2_ll} + {s2_hl[36:0], 27'b0} + {s2_hh, 52'b0};
      s3_f  <= 64'($signed(ff_c) >>> 19);
      p3    <= p2;
      z3    <= z2;
      d3    <= d2;
      // stage 4: square times p9
      s4_el <= el_c;
      s4_eh <= eh_c;
      s4_f  <= s3_f;
      p4    <= p3;
      z4    <= z3;
      d4    <= d3;
      // stage 5: final sum
      pressure_q24_8    <= z4 ? 32'd0 : res_c;
      temperature_centi <= d4.temp;
      humidity_q22_10   <= d4.hum;
    end
  end

endmodule

/* src/sensor_calibration_compensation_core.sv */
`timescale 1ns / 1ps
// top level of the sensor calibration compensation core
//
// Integer compensation of one raw temperature/pressure/humidity burst per
// s_tdata word into temperature (0.01 degC), pressure (Q24.8 Pa, 0 when the
// pressure divisor is zero) and humidity (Q22.10 %, clamped to 0..100).
// The datapath is one stall-together pipeline: 3 stages for the fine
// temperature, 6 stages for the pressure divider operands with the humidity
// chain beside them, 64 stages of a one-bit-per-stage divider and 5 stages of
// pressure correction, then a two-word output buffer. A new word can be
// accepted every cycle while s_tready is high; the 64-step divider sets
// the latency. s_tready is registered and drops only when the output
// buffer holds two unclaimed words, so the pipeline keeps running while
// one result waits on m_tready. Coefficient registers are written
// through cfg_wen/cfg_index/cfg_data and must only be changed while no
// word is in flight.
module sensor_calibration_compensation_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // raw_temperature [19:0], raw_pressure [39:20], raw_humidity [55:40]
  input  logic [55:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // temperature_centi [23:0], pressure_q24_8 [55:24], humidity_q22_10 [72:56], zero [79:73]
  output logic [79:0] m_tdata,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // coefficient registers
  logic [47:0] temp_coeffs;
  logic [63:0] press_coeffs_low;
  logic [63:0] press_coeffs_high;
  logic [47:0] press_hum_coeffs;
  logic [31:0] hum_coeffs;
  scc_pkg::coeff_t coeff;

  // pipeline advance, held off only by a full output buffer
  logic ce;

  logic               t_vld;
  logic signed [31:0] t_tf;
  logic [19:0]        t_adc_p;
  logic [15:0]        t_adc_h;

  logic               pre_vld;
  logic [63:0]        pre_num;
  logic [30:0]        pre_den;
  logic               pre_neg;
  logic               pre_zero;
  logic [23:0]        pre_temp;
  logic [16:0]        hum;
  scc_pkg::side_t     pre_side;

  logic               div_vld;
  logic [63:0]        div_quot;
  logic               div_neg;
  logic               div_zero;
  scc_pkg::side_t     div_side;

  logic               post_vld;
  logic [23:0]        post_temp;
  logic [31:0]        post_pres;
  logic [16:0]        post_hum;
  logic [79:0]        post_word;

  // output buffer: head drives the port, skid catches one more word
  logic               head_vld;
  logic               skid_vld;
  logic [79:0]        head_data;
  logic [79:0]        skid_data;
  logic               push;
  logic               pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs       <= '0;
      press_coeffs_low  <= '0;
      press_coeffs_high <= '0;
      press_hum_coeffs  <= '0;
      hum_coeffs        <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        scc_pkg::REG_TEMP:      temp_coeffs       <= cfg_data[47:0];
        scc_pkg::REG_PRESS_LO:  press_coeffs_low  <= cfg_data;
        scc_pkg::REG_PRESS_HI:  press_coeffs_high <= cfg_data;
        scc_pkg::REG_PRESS_HUM: press_hum_coeffs  <= cfg_data[47:0];
        scc_pkg::REG_HUM:       hum_coeffs        <= cfg_data[31:0];
        default: ; // unused indexes are dropped
      endcase
    end
  end

  // coefficient slices
  always_comb begin
    coeff.t1 = temp_coeffs[15:0];
    coeff.t2 = temp_coeffs[31:16];
    coeff.t3 = temp_coeffs[47:32];
    coeff.p1 = press_coeffs_low[15:0];
    coeff.p2 = press_coeffs_low[31:16];
    coeff.p3 = press_coeffs_low[47:32];
    coeff.p4 = press_coeffs_low[63:48];
    coeff.p5 = press_coeffs_high[15:0];
    coeff.p6 = press_coeffs_high[31:16];
    coeff.p7 = press_coeffs_high[47:32];
    coeff.p8 = press_coeffs_high[63:48];
    coeff.p9 = press_hum_coeffs[15:0];
    coeff.h1 = press_hum_coeffs[23:16];
    coeff.h2 = press_hum_coeffs[39:24];
    coeff.h3 = press_hum_coeffs[47:40];
    coeff.h4 = hum_coeffs[11:0];
    coeff.h5 = hum_coeffs[23:12];
    coeff.h6 = hum_coeffs[31:24];
  end

  assign ce       = !skid_vld;
  assign s_tready = ce;

  scc_temp u_temp (
    .clk             (clk),
    .rst             (rst),
    .ce              (ce),
    .in_vld          (s_tvalid),
    .raw_temperature (s_tdata[19:0]),
    .raw_pressure    (s_tdata[39:20]),
    .raw_humidity    (s_tdata[55:40]),
    .coeff           (coeff),
    .out_vld         (t_vld),
    .tf              (t_tf),
    .adc_p           (t_adc_p),
    .adc_h           (t_adc_h)
  );

  scc_ppre u_ppre (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_vld   (t_vld),
    .tf       (t_tf),
    .adc_p    (t_adc_p),
    .coeff    (coeff),
    .out_vld  (pre_vld),
    .num_mag  (pre_num),
    .den_mag  (pre_den),
    .q_neg    (pre_neg),
    .den_zero (pre_zero),
    .temp     (pre_temp)
  );

  // humidity runs beside the pressure front end with the same latency
  scc_hum u_hum (
    .clk   (clk),
    .ce    (ce),
    .tf    (t_tf),
    .adc_h (t_adc_h),
    .coeff (coeff),
    .hum   (hum)
  );

  assign pre_side.hum  = hum;
  assign pre_side.temp = pre_temp;

  scc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_vld   (pre_vld),
    .num_mag  (pre_num),
    .den_mag  (pre_den),
    .q_neg    (pre_neg),
    .den_zero (pre_zero),
    .side     (pre_side),
    .out_vld  (div_vld),
    .quot     (div_quot),
    .out_neg  (div_neg),
    .out_zero (div_zero),
    .out_side (div_side)
  );

  scc_ppost u_ppost (
    .clk               (clk),
    .rst               (rst),
    .ce                (ce),
    .in_vld            (div_vld),
    .quot              (div_quot),
    .q_neg             (div_neg),
    .den_zero          (div_zero),
    .side              (div_side),
    .coeff             (coeff),
    .out_vld           (post_vld),
    .temperature_centi (post_temp),
    .pressure_q24_8    (post_pres),
    .humidity_q22_10   (post_hum)
  );

  assign post_word = {7'b0, post_hum, post_pres, post_temp};
  assign push      = ce && post_vld;
  assign pop       = head_vld && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_vld <= 1'b0;
      skid_vld <= 1'b0;
    end else if (pop || !head_vld) begin
      if (skid_vld) begin
        head_vld <= 1'b1;
        skid_vld <= push;
      end else begin
        head_vld <= push;
      end
    end else if (push) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !head_vld) begin
      if (skid_vld) begin
        head_data <= skid_data;
        skid_data <= post_word;
      end else begin
        head_data <= post_word;
      end
    end else if (push) begin
      skid_data <= post_word;
    end
  end

  assign m_tvalid = head_vld;
  assign m_tdata  = head_data;

endmodule

/* src/scc_chk.sv */
`timescale 1ns / 1ps
// port-level checker for the compensation core, bound to the top level
module scc_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata
);

  // nothing comes out right after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word right after reset");

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed");

  // humidity clamp
  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[72:56] <= 17'd102400)
    else $error("humidity above full scale");

  // pad bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[79:73] == 7'd0)
    else $error("nonzero pad bits");

  // an empty output buffer never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");

endmodule

bind sensor_calibration_compensation_core scc_chk u_scc_chk (.*);
